### rtl/ntc_pkg.sv
// ntc_pkg: shared widths, codes, reset values and fixed-point constants
// for the NTC thermistor temperature pipeline. No dependencies.
package ntc_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int SAMPLE_W     = 16;
    localparam int SUPPLY_W     = 13;
    localparam int BITS_W       = 5;
    localparam int RES_W        = 20;
    localparam int BETA_W       = 16;
    localparam int UNIT_W       = 2;
    localparam int TEMP_W       = 16;
    localparam int PROD_W       = RES_W + SAMPLE_W;
    localparam int EXP_W        = 6;
    localparam int INT_CAP_BITS = 20;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;
    localparam int MAGC_W       = 18;

    localparam logic [BITS_W-1:0] ADC_BITS_MIN = 5'd1;
    localparam logic [BITS_W-1:0] ADC_BITS_MAX = 5'd16;

    localparam logic [SUPPLY_W-1:0] RST_SUPPLY = 13'd3300;
    localparam logic [BITS_W-1:0]   RST_BITS   = 5'd10;
    localparam logic [RES_W-1:0]    RST_SERIES = 20'd10000;
    localparam logic [BETA_W-1:0]   RST_BETA   = 16'd3950;
    localparam logic [RES_W-1:0]    RST_NOM    = 20'd10000;
    localparam logic [UNIT_W-1:0]   RST_UNIT   = 2'd0;

    localparam logic [MAGC_W-1:0] FIVE_RECIP = 18'd209716;
    localparam logic [MAGC_W-1:0] TEMP_MAX   = 18'd32767;
    localparam logic [MAGC_W-1:0] TEMP_MINM  = 18'd32768;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_ZERO   = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        UNIT_C    = 2'd0,
        UNIT_F    = 2'd1,
        UNIT_K    = 2'd2,
        UNIT_NONE = 2'd3
    } t_unit;

    typedef enum logic [2:0] {
        REG_SUPPLY = 3'd0,
        REG_BITS   = 3'd1,
        REG_SERIES = 3'd2,
        REG_BETA   = 3'd3,
        REG_NOM    = 3'd4,
        REG_UNIT   = 3'd5
    } t_reg_index;

    function automatic logic [63:0] ln2_q(input int f);
        return (64'd2977044472 + (64'd1 << (31 - f))) >> (32 - f);
    endfunction

    function automatic logic [63:0] t0_q(input int f);
        return (64'd29815 * (64'd1 << f) + 64'd50) / 64'd100;
    endfunction

    function automatic logic [63:0] k0_q(input int f);
        return (64'd27315 * (64'd1 << f) + 64'd50) / 64'd100;
    endfunction

endpackage

### rtl/ntc_log2.sv
// ntc_log2: two-lane pipelined log2 in fixed point, a normalization stage then one squaring step per stage.
// Depends on ntc_pkg.
module ntc_log2 #(
    parameter int FRACTION_BITS = ntc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  ntc_pkg::t_status                           i_status,
    input  logic [ntc_pkg::PROD_W-1:0]                 i_num,
    input  logic [ntc_pkg::PROD_W-1:0]                 i_den,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output ntc_pkg::t_status                           o_status,
    output logic [ntc_pkg::EXP_W+FRACTION_BITS-1:0]    o_log_num,
    output logic [ntc_pkg::EXP_W+FRACTION_BITS-1:0]    o_log_den
);
    import ntc_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int N   = F + 1;
    localparam int M_W = F + 1;

    function automatic logic [EXP_W-1:0] top_bit(input logic [PROD_W-1:0] v);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (v[i]) e = EXP_W'(i);
        end
        return e;
    endfunction

    function automatic logic [M_W-1:0] mant(input logic [PROD_W-1:0] v,
                                            input logic [EXP_W-1:0] e);
        logic [PROD_W+F-1:0] ext;
        ext = {v, {F{1'b0}}} >> e;
        return ext[M_W-1:0];
    endfunction

    // returns {emitted bit, next mantissa}
    function automatic logic [M_W:0] square_step(input logic [M_W-1:0] m);
        logic [2*M_W-1:0] sq;
        logic [M_W:0]     t;
        sq = (2*M_W)'(m) * (2*M_W)'(m);
        t  = sq[2*F+1:F];
        if (t[M_W]) return {1'b1, t[M_W:1]};
        else return {1'b0, t[M_W-1:0]};
    endfunction

    logic             r_v    [N];
    t_status          r_st   [N];
    logic [EXP_W-1:0] r_e_n  [N];
    logic [EXP_W-1:0] r_e_d  [N];
    logic [M_W-1:0]   r_m_n  [N];
    logic [M_W-1:0]   r_m_d  [N];
    logic [F-1:0]     r_fr_n [N];
    logic [F-1:0]     r_fr_d [N];
    logic             stall  [N+1];

    assign stall[N] = i_stall;
    assign o_stall  = stall[0];

    for (genvar k = 0; k < N; k++) begin : g_stage
        assign stall[k] = r_v[k] && stall[k+1];
        if (k == 0) begin : g_norm
            logic [EXP_W-1:0] n_e_n, n_e_d;
            assign n_e_n = top_bit(i_num);
            assign n_e_d = top_bit(i_den);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (!stall[k]) begin
                    r_v[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!stall[k]) begin
                    r_st[k]   <= i_status;
                    r_e_n[k]  <= n_e_n;
                    r_e_d[k]  <= n_e_d;
                    r_m_n[k]  <= mant(i_num, n_e_n);
                    r_m_d[k]  <= mant(i_den, n_e_d);
                    r_fr_n[k] <= '0;
                    r_fr_d[k] <= '0;
                end
            end
        end else begin : g_sq
            logic [M_W:0] n_sq_n, n_sq_d;
            assign n_sq_n = square_step(r_m_n[k-1]);
            assign n_sq_d = square_step(r_m_d[k-1]);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (!stall[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!stall[k]) begin
                    r_st[k]   <= r_st[k-1];
                    r_e_n[k]  <= r_e_n[k-1];
                    r_e_d[k]  <= r_e_d[k-1];
                    r_m_n[k]  <= n_sq_n[M_W-1:0];
                    r_m_d[k]  <= n_sq_d[M_W-1:0];
                    r_fr_n[k] <= {r_fr_n[k-1][F-2:0], n_sq_n[M_W]};
                    r_fr_d[k] <= {r_fr_d[k-1][F-2:0], n_sq_d[M_W]};
                end
            end
        end
    end

    assign o_valid   = r_v[N-1];
    assign o_status  = r_st[N-1];
    assign o_log_num = {r_e_n[N-1], r_fr_n[N-1]};
    assign o_log_den = {r_e_d[N-1], r_fr_d[N-1]};

endmodule

### rtl/ntc_denom.sv
// ntc_denom: log difference to ln, Beta-equation denominator and numerator.
// Four pipeline stages. Depends on ntc_pkg.
module ntc_denom #(
    parameter int FRACTION_BITS = ntc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  ntc_pkg::t_status                            i_status,
    input  logic [ntc_pkg::EXP_W+FRACTION_BITS-1:0]     i_log_num,
    input  logic [ntc_pkg::EXP_W+FRACTION_BITS-1:0]     i_log_den,
    input  logic [ntc_pkg::BETA_W-1:0]                  i_beta,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output ntc_pkg::t_status                            o_status,
    output logic [ntc_pkg::BETA_W+FRACTION_BITS+8:0]    o_nq,
    output logic [ntc_pkg::BETA_W+FRACTION_BITS:0]      o_mag,
    output logic                                        o_neg
);
    import ntc_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int LOG_W = EXP_W + F;
    localparam int T0_W  = F + 9;
    localparam int PQ_W  = T0_W + LOG_W - F;
    localparam int DQ_W  = BETA_W + F + 2;
    localparam int MAG_W = BETA_W + F + 1;
    localparam int NQ_W  = BETA_W + T0_W;

    localparam logic [F-1:0]    LN2Q = F'(ln2_q(F));
    localparam logic [T0_W-1:0] T0Q  = T0_W'(t0_q(F));

    logic             r_v0, r_v1, r_v2, r_v3;
    t_status          r_st0, r_st1, r_st2, r_st3;
    logic             r_neg0, r_neg1, r_neg2, r_neg3;
    logic [LOG_W-1:0] r_dmag0, r_lmag1;
    logic [PQ_W-1:0]  r_prod2;
    logic [NQ_W-1:0]  r_nq3;
    logic [MAG_W-1:0] r_mag3;
    logic             stall0, stall1, stall2, stall3;

    assign stall3  = r_v3 && i_stall;
    assign stall2  = r_v2 && stall3;
    assign stall1  = r_v1 && stall2;
    assign stall0  = r_v0 && stall1;
    assign o_stall = stall0;

    logic                    n_neg0;
    logic [LOG_W-1:0]        n_dmag0;
    logic [LOG_W+F-1:0]      n_lprod;
    logic [T0_W+LOG_W-1:0]   n_pprod;
    logic [BETA_W-1:0]       b_eff;
    logic signed [DQ_W-1:0]  bq, pq, n_dq, dq_inv;
    logic [NQ_W-1:0]         n_nq;

    assign n_neg0  = i_log_den > i_log_num;
    assign n_dmag0 = n_neg0 ? i_log_den - i_log_num : i_log_num - i_log_den;
    assign n_lprod = (LOG_W+F)'(r_dmag0) * (LOG_W+F)'(LN2Q);
    assign n_pprod = (T0_W+LOG_W)'(r_lmag1) * (T0_W+LOG_W)'(T0Q);
    assign b_eff   = (i_beta == '0) ? BETA_W'(1) : i_beta;
    assign bq      = $signed({2'b00, b_eff, {F{1'b0}}});
    assign pq      = $signed(DQ_W'(r_prod2));
    assign n_dq    = r_neg2 ? bq - pq : bq + pq;
    assign dq_inv  = -n_dq;
    assign n_nq    = NQ_W'(b_eff) * NQ_W'(T0Q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!stall0) r_v0 <= i_valid;
            if (!stall1) r_v1 <= r_v0;
            if (!stall2) r_v2 <= r_v1;
            if (!stall3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall0) begin
            r_st0   <= i_status;
            r_neg0  <= n_neg0;
            r_dmag0 <= n_dmag0;
        end
        if (!stall1) begin
            r_st1   <= r_st0;
            r_neg1  <= r_neg0;
            r_lmag1 <= n_lprod[LOG_W+F-1:F];
        end
        if (!stall2) begin
            r_st2   <= r_st1;
            r_neg2  <= r_neg1;
            r_prod2 <= n_pprod[T0_W+LOG_W-1:F];
        end
        if (!stall3) begin
            r_st3  <= r_st2;
            r_neg3 <= n_dq[DQ_W-1];
            r_mag3 <= n_dq[DQ_W-1] ? dq_inv[MAG_W-1:0] : n_dq[MAG_W-1:0];
            r_nq3  <= n_nq;
        end
    end

    assign o_valid  = r_v3;
    assign o_status = r_st3;
    assign o_nq     = r_nq3;
    assign o_mag    = r_mag3;
    assign o_neg    = r_neg3;

endmodule

### rtl/ntc_div.sv
// ntc_div: pipelined restoring divider, an initial stage then one quotient bit per stage, with
// the integer cap. Depends on ntc_pkg.
module ntc_div #(
    parameter int FRACTION_BITS = ntc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_stall,
    input  ntc_pkg::t_status                                  i_status,
    input  logic [ntc_pkg::BETA_W+FRACTION_BITS+8:0]          i_nq,
    input  logic [ntc_pkg::BETA_W+FRACTION_BITS:0]            i_mag,
    input  logic                                              i_neg,
    output logic                                              o_valid,
    input  logic                                              i_stall,
    output ntc_pkg::t_status                                  o_status,
    output logic [ntc_pkg::INT_CAP_BITS+FRACTION_BITS:0]      o_quo,
    output logic                                              o_neg
);
    import ntc_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int MAG_W = BETA_W + F + 1;
    localparam int NQ_W  = BETA_W + F + 9;
    localparam int HI_W  = NQ_W - INT_CAP_BITS;
    localparam int QB    = INT_CAP_BITS + F;
    localparam int NS    = QB + 1;
    localparam int QW    = QB + 1;

    logic                    r_v   [NS];
    t_status                 r_st  [NS];
    logic                    r_neg [NS];
    logic                    r_cap [NS];
    logic [MAG_W-1:0]        r_mag [NS];
    logic [MAG_W-1:0]        r_rem [NS];
    logic [INT_CAP_BITS-1:0] r_lo  [NS];
    logic [QB-1:0]           r_q   [NS];
    logic                    stall [NS+1];

    assign stall[NS] = i_stall;
    assign o_stall   = stall[0];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        assign stall[k] = r_v[k] && stall[k+1];
        if (k == 0) begin : g_init
            logic [MAG_W-1:0] hi;
            logic             n_cap;
            assign hi    = MAG_W'(i_nq[NQ_W-1:INT_CAP_BITS]);
            assign n_cap = hi >= i_mag;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (!stall[k]) begin
                    r_v[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!stall[k]) begin
                    r_st[k]  <= i_status;
                    r_neg[k] <= i_neg;
                    r_cap[k] <= n_cap;
                    r_mag[k] <= i_mag;
                    r_rem[k] <= n_cap ? '0 : hi;
                    r_lo[k]  <= i_nq[INT_CAP_BITS-1:0];
                    r_q[k]   <= '0;
                end
            end
        end else begin : g_step
            logic             nbit;
            logic [MAG_W:0]   t, td;
            logic             ge;
            if (k <= INT_CAP_BITS) begin : g_int
                assign nbit = r_lo[k-1][INT_CAP_BITS-k];
            end else begin : g_frac
                assign nbit = 1'b0;
            end
            assign t  = {r_rem[k-1], nbit};
            assign ge = t >= {1'b0, r_mag[k-1]};
            assign td = t - {1'b0, r_mag[k-1]};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (!stall[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!stall[k]) begin
                    r_st[k]  <= r_st[k-1];
                    r_neg[k] <= r_neg[k-1];
                    r_cap[k] <= r_cap[k-1];
                    r_mag[k] <= r_mag[k-1];
                    r_rem[k] <= ge ? td[MAG_W-1:0] : t[MAG_W-1:0];
                    r_lo[k]  <= r_lo[k-1];
                    r_q[k]   <= {r_q[k-1][QB-2:0], ge};
                end
            end
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_status = r_st[NS-1];
    assign o_neg    = r_neg[NS-1];
    assign o_quo    = r_cap[NS-1] ? (QW'(1) << QB) : {1'b0, r_q[NS-1]};

endmodule

### rtl/ntc_conv.sv
// ntc_conv: unit conversion, truncation toward zero and int16 saturation.
// Four pipeline stages, the last one is the output register. Depends on ntc_pkg.
module ntc_conv #(
    parameter int FRACTION_BITS = ntc_pkg::FRACTION_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_stall,
    input  ntc_pkg::t_status                              i_status,
    input  logic [ntc_pkg::INT_CAP_BITS+FRACTION_BITS:0]  i_quo,
    input  logic                                          i_neg,
    input  logic [ntc_pkg::UNIT_W-1:0]                    i_unit,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic signed [ntc_pkg::TEMP_W-1:0]             o_temperature,
    output logic [1:0]                                    o_status
);
    import ntc_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int QW   = INT_CAP_BITS + F + 1;
    localparam int TQ_W = QW + 1;
    localparam int X_W  = TQ_W + 1;
    localparam int Y_W  = X_W + 4;
    localparam int SH_W = Y_W - F;

    localparam logic signed [X_W-1:0] K0Q   = X_W'(k0_q(F));
    localparam logic signed [Y_W-1:0] OFS_F = Y_W'(160) <<< F;
    localparam logic [SH_W-1:0]       CLAMP = SH_W'((1 << MAGC_W) - 1);

    logic                    r_v0, r_v1, r_v2, r_v3;
    t_status                 r_st0, r_st1, r_st2, r_st3;
    logic signed [TQ_W-1:0]  r_tq0;
    logic signed [X_W-1:0]   r_x0;
    logic signed [Y_W-1:0]   r_val1;
    logic                    r_isf1, r_zero1, r_isf2, r_zero2, r_neg2;
    logic [MAGC_W-1:0]       r_mag2;
    logic signed [TEMP_W-1:0] r_temp;
    logic                    stall0, stall1, stall2, stall3;

    assign stall3  = r_v3 && i_stall;
    assign stall2  = r_v2 && stall3;
    assign stall1  = r_v1 && stall2;
    assign stall0  = r_v0 && stall1;
    assign o_stall = stall0;

    logic [QW-1:0]          tqm;
    logic signed [TQ_W-1:0] tqs, n_tq;
    logic signed [Y_W-1:0]  xe, ye, n_val;
    logic                   n_isf, n_zero;
    logic [Y_W-1:0]         vabs;
    logic [SH_W-1:0]        sh;
    logic [2*MAGC_W-1:0]    prod5;
    logic [MAGC_W-1:0]      q;
    logic [MAGC_W:0]        qneg;
    logic signed [TEMP_W-1:0] n_temp;

    assign tqm  = (i_status != ST_NORMAL) ? '0 : i_quo;
    assign tqs  = $signed({1'b0, tqm});
    assign n_tq = i_neg ? -tqs : tqs;

    assign xe = Y_W'(r_x0);
    assign ye = (xe <<< 3) + xe + OFS_F;

    always_comb begin
        n_val  = '0;
        n_isf  = 1'b0;
        n_zero = 1'b0;
        unique case (t_unit'(i_unit))
            UNIT_C: begin
                n_val = xe;
            end
            UNIT_F: begin
                n_val = ye;
                n_isf = 1'b1;
            end
            UNIT_K: begin
                n_val = Y_W'(r_tq0);
            end
            UNIT_NONE: begin
                n_zero = 1'b1;
            end
        endcase
    end

    assign vabs  = r_val1[Y_W-1] ? $unsigned(-r_val1) : $unsigned(r_val1);
    assign sh    = vabs[Y_W-1:F];
    assign prod5 = (2*MAGC_W)'(r_mag2) * (2*MAGC_W)'(FIVE_RECIP);
    assign q     = r_isf2 ? MAGC_W'(prod5[2*MAGC_W-1:20]) : r_mag2;
    assign qneg  = -{1'b0, q};

    always_comb begin
        priority if (r_zero2) begin
            n_temp = '0;
        end else if (r_neg2) begin
            n_temp = (q > TEMP_MINM) ? $signed({1'b1, {(TEMP_W-1){1'b0}}})
                                     : $signed(qneg[TEMP_W-1:0]);
        end else begin
            n_temp = (q > TEMP_MAX) ? $signed({1'b0, {(TEMP_W-1){1'b1}}})
                                    : $signed(q[TEMP_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (!stall0) r_v0 <= i_valid;
            if (!stall1) r_v1 <= r_v0;
            if (!stall2) r_v2 <= r_v1;
            if (!stall3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall0) begin
            r_st0 <= i_status;
            r_tq0 <= n_tq;
            r_x0  <= X_W'(n_tq) - K0Q;
        end
        if (!stall1) begin
            r_st1   <= r_st0;
            r_val1  <= n_val;
            r_isf1  <= n_isf;
            r_zero1 <= n_zero;
        end
        if (!stall2) begin
            r_st2   <= r_st1;
            r_isf2  <= r_isf1;
            r_zero2 <= r_zero1;
            r_neg2  <= r_val1[Y_W-1];
            r_mag2  <= (sh > CLAMP) ? CLAMP[MAGC_W-1:0] : sh[MAGC_W-1:0];
        end
        if (!stall3) begin
            r_st3  <= r_st2;
            r_temp <= n_temp;
        end
    end

    assign o_valid       = r_v3;
    assign o_temperature = r_temp;
    assign o_status      = r_st3;

endmodule

### rtl/ntc_thermistor_temperature.sv
// Throughput: one transaction per cycle; every stage holds one item, a stall
// freezes only the occupied stages behind the output register.
// Depth is set by the log2 squaring chain and the bit-per-stage divider.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
// Top level: APB register file, input stage, log2, denominator, divider, conversion.
module ntc_thermistor_temperature #(
    parameter int FRACTION_BITS = ntc_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [ntc_pkg::SAMPLE_W-1:0]       i_adc_sample,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [ntc_pkg::TEMP_W-1:0]  o_temperature,
    output logic [1:0]                         o_status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ntc_pkg::ADDR_W-1:0]         paddr,
    input  logic [ntc_pkg::DATA_W-1:0]         pwdata,
    output logic [ntc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import ntc_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int LOG_W = EXP_W + F;
    localparam int NQ_W  = BETA_W + F + 9;
    localparam int MAG_W = BETA_W + F + 1;
    localparam int QW    = INT_CAP_BITS + F + 1;

    logic [SUPPLY_W-1:0] r_supply;
    logic [BITS_W-1:0]   r_adc_bits;
    logic [RES_W-1:0]    r_series;
    logic [BETA_W-1:0]   r_beta;
    logic [RES_W-1:0]    r_nom;
    logic [UNIT_W-1:0]   r_unit;

    logic wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply   <= RST_SUPPLY;
            r_adc_bits <= RST_BITS;
            r_series   <= RST_SERIES;
            r_beta     <= RST_BETA;
            r_nom      <= RST_NOM;
            r_unit     <= RST_UNIT;
        end else if (wr_en) begin
            unique case (t_reg_index'(paddr[ADDR_W-1:2]))
                REG_SUPPLY: r_supply   <= pwdata[SUPPLY_W-1:0];
                REG_BITS:   r_adc_bits <= pwdata[BITS_W-1:0];
                REG_SERIES: r_series   <= pwdata[RES_W-1:0];
                REG_BETA:   r_beta     <= pwdata[BETA_W-1:0];
                REG_NOM:    r_nom      <= pwdata[RES_W-1:0];
                REG_UNIT:   r_unit     <= pwdata[UNIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_index'(paddr[ADDR_W-1:2]))
            REG_SUPPLY: prdata = DATA_W'(r_supply);
            REG_BITS:   prdata = DATA_W'(r_adc_bits);
            REG_SERIES: prdata = DATA_W'(r_series);
            REG_BETA:   prdata = DATA_W'(r_beta);
            REG_NOM:    prdata = DATA_W'(r_nom);
            REG_UNIT:   prdata = DATA_W'(r_unit);
            default:    prdata = '0;
        endcase
    end

    // input stage: full scale, special cases, resistance ratio numerator and denominator products
    logic [BITS_W-1:0]   bits_eff;
    logic [SAMPLE_W:0]   fs_w;
    logic [SAMPLE_W-1:0] fs;
    logic [RES_W-1:0]    rs_eff, rn_eff;
    t_status             n_status;
    logic [PROD_W-1:0]   n_num, n_den;

    always_comb begin
        priority if (r_adc_bits < ADC_BITS_MIN) bits_eff = ADC_BITS_MIN;
        else if (r_adc_bits > ADC_BITS_MAX) bits_eff = ADC_BITS_MAX;
        else bits_eff = r_adc_bits;
    end

    assign fs_w   = ((SAMPLE_W+1)'(1) << bits_eff) - (SAMPLE_W+1)'(1);
    assign fs     = fs_w[SAMPLE_W-1:0];
    assign rs_eff = (r_series == '0) ? RES_W'(1) : r_series;
    assign rn_eff = (r_nom == '0) ? RES_W'(1) : r_nom;

    always_comb begin
        priority if (i_adc_sample == '0) n_status = ST_ZERO;
        else if (i_adc_sample >= fs) n_status = ST_FULL;
        else n_status = ST_NORMAL;
    end

    assign n_num = (n_status == ST_NORMAL) ? PROD_W'(rs_eff) * PROD_W'(i_adc_sample)
                                           : PROD_W'(1);
    assign n_den = (n_status == ST_NORMAL) ? PROD_W'(fs - i_adc_sample) * PROD_W'(rn_eff)
                                           : PROD_W'(1);

    logic              r_f_valid;
    t_status           r_f_status;
    logic [PROD_W-1:0] r_f_num, r_f_den;
    logic              log_stall, f_stall;

    assign f_stall = r_f_valid && log_stall;
    assign o_stall = f_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (!f_stall) begin
            r_f_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!f_stall) begin
            r_f_status <= n_status;
            r_f_num    <= n_num;
            r_f_den    <= n_den;
        end
    end

    logic             lg_valid, dn_stall;
    t_status          lg_status;
    logic [LOG_W-1:0] lg_num, lg_den;

    ntc_log2 #(.FRACTION_BITS(F)) u_log2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_f_valid),
        .o_stall   (log_stall),
        .i_status  (r_f_status),
        .i_num     (r_f_num),
        .i_den     (r_f_den),
        .o_valid   (lg_valid),
        .i_stall   (dn_stall),
        .o_status  (lg_status),
        .o_log_num (lg_num),
        .o_log_den (lg_den)
    );

    logic             dn_valid, dv_stall, dn_neg;
    t_status          dn_status;
    logic [NQ_W-1:0]  dn_nq;
    logic [MAG_W-1:0] dn_mag;

    ntc_denom #(.FRACTION_BITS(F)) u_denom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (lg_valid),
        .o_stall   (dn_stall),
        .i_status  (lg_status),
        .i_log_num (lg_num),
        .i_log_den (lg_den),
        .i_beta    (r_beta),
        .o_valid   (dn_valid),
        .i_stall   (dv_stall),
        .o_status  (dn_status),
        .o_nq      (dn_nq),
        .o_mag     (dn_mag),
        .o_neg     (dn_neg)
    );

    logic          dv_valid, cv_stall, dv_neg;
    t_status       dv_status;
    logic [QW-1:0] dv_quo;

    ntc_div #(.FRACTION_BITS(F)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dn_valid),
        .o_stall  (dv_stall),
        .i_status (dn_status),
        .i_nq     (dn_nq),
        .i_mag    (dn_mag),
        .i_neg    (dn_neg),
        .o_valid  (dv_valid),
        .i_stall  (cv_stall),
        .o_status (dv_status),
        .o_quo    (dv_quo),
        .o_neg    (dv_neg)
    );

    ntc_conv #(.FRACTION_BITS(F)) u_conv (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (dv_valid),
        .o_stall       (cv_stall),
        .i_status      (dv_status),
        .i_quo         (dv_quo),
        .i_neg         (dv_neg),
        .i_unit        (r_unit),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_temperature (o_temperature),
        .o_status      (o_status)
    );

`ifndef SYNTHESIS
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && log_stall |=> r_f_valid)
        else $error("input stage dropped a held transaction");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_f_valid)
        else $error("accepted transaction not captured");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_f_valid)
        else $error("valid bits not cleared by reset");

    a_supply_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en |=> $stable(r_supply))
        else $error("supply register changed without a write");
`endif

endmodule
